// ===== rtl/bezp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezp_pkg
// Shared widths, register indexes, pipeline stage map and control types for
// the quadratic Bezier point unit.
// ----------------------------------------------------------------------------
package bezp_pkg;

  localparam int COORD_W   = 15;
  localparam int STEP_W    = 16;
  localparam int RAD_W     = 21;
  localparam int RES_W     = 32;
  localparam int REG_IDX_W = 3;
  localparam int WR_DATA_W = RAD_W;

  // restoring divider for t: quotient bits resolved per stage, and stage count
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = STEP_W / DIV_BITS;

  // pipeline stage map
  localparam int ST_IDX     = 0;
  localparam int ST_DIV0    = 1;
  localparam int ST_MUL     = ST_DIV0 + DIV_STAGES;
  localparam int ST_PROD    = ST_MUL + 1;
  localparam int ST_SUM     = ST_PROD + 1;
  localparam int ST_OUT     = ST_SUM + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 16'd4800;
  localparam logic [RAD_W-1:0]  RADIUS_RESET     = 21'd32768;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_CTRL_X     = 3'd2,
    REG_CTRL_Y     = 3'd3,
    REG_END_X      = 3'd4,
    REG_END_Y      = 3'd5,
    REG_STEP_COUNT = 3'd6,
    REG_RADIUS     = 3'd7
  } bezp_reg_e;

  typedef struct packed {
    logic en_mul;
    logic en_prod;
    logic en_sum;
  } bezp_axis_ctl_t;

endpackage

// ===== rtl/bezp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezp_in_if
// Step index channel: valid/ready handshake carrying one curve step index.
// ----------------------------------------------------------------------------
interface bezp_in_if import bezp_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_index;

  modport source (output valid, output step_index, input ready);
  modport sink   (input valid, input step_index, output ready);

endinterface

// ===== rtl/bezp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezp_out_if
// Marker box channel: valid/ready handshake carrying the box around one
// curve point and the last step flag.
// ----------------------------------------------------------------------------
interface bezp_out_if import bezp_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] x_low;
  logic signed [RES_W-1:0] y_low;
  logic signed [RES_W-1:0] x_high;
  logic signed [RES_W-1:0] y_high;
  logic                    last_step;

  modport source (output valid, output x_low, output y_low, output x_high,
                  output y_high, output last_step, input ready);
  modport sink   (input valid, input x_low, input y_low, input x_high,
                  input y_high, input last_step, output ready);

endinterface

// ===== rtl/bezp_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezp_div_stage
// One stage of the pipelined restoring divider that forms t. Resolves
// DIV_BITS quotient bits per cycle while en is high; the remainder entering is
// always below the divisor, so a single compare and subtract settles each bit.
// ----------------------------------------------------------------------------
module bezp_div_stage import bezp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [STEP_W-1:0] divisor,
  input  logic [STEP_W-1:0] rem_in,
  input  logic [STEP_W-1:0] quo_in,
  output logic [STEP_W-1:0] rem_out,
  output logic [STEP_W-1:0] quo_out
);

  logic [STEP_W-1:0]   rem_next;
  logic [DIV_BITS-1:0] qbits;

  always_comb begin : div_steps
    logic [STEP_W:0]   shifted;
    logic [STEP_W-1:0] r;
    r     = rem_in;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      shifted = {r, 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        shifted                  = shifted - {1'b0, divisor};
        qbits[DIV_BITS-1-i]      = 1'b1;
      end
      r = shifted[STEP_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      quo_out <= {quo_in[STEP_W-DIV_BITS-1:0], qbits};
    end
  end

endmodule

// ===== rtl/bezp_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezp_axis
// Curve coordinate for one axis. The two de Casteljau levels fold into
//   r = c0*2^16 + 2*t*(c1-c0) + floor(t*t*(c2-2*c1+c0) / 2^16)
// which is exact for integer control points. Three register stages:
// products with t, product with t*t, final sum.
// ----------------------------------------------------------------------------
module bezp_axis import bezp_pkg::*; (
  input  logic                     clk,
  input  bezp_axis_ctl_t           ctl,
  input  logic [STEP_W-1:0]        t,
  input  logic signed [COORD_W-1:0] c0,
  input  logic signed [COORD_W-1:0] c1,
  input  logic signed [COORD_W-1:0] c2,
  output logic [RES_W-1:0]         r
);

  logic signed [COORD_W:0]   d0;
  logic signed [COORD_W+1:0] e;

  logic signed [STEP_W+COORD_W+1:0]          lin;
  logic        [2*STEP_W-1:0]                t_sq;
  logic signed [STEP_W+COORD_W+1:0]          lin_b;
  logic signed [2*STEP_W+COORD_W+2:0]        quad;

  // user must change config only while idle (not enforced here); these are then static during operation
  assign d0 = COORD_W'(c1) - COORD_W'(c0) + (COORD_W+1)'(0);
  assign e  = (COORD_W+2)'(c2) - ((COORD_W+2)'(c1) <<< 1) + (COORD_W+2)'(c0);

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      lin  <= $signed({1'b0, t}) * d0;
      t_sq <= t * t;
    end
    if (ctl.en_prod) begin
      lin_b <= lin;
      quad  <= $signed({1'b0, t_sq}) * e;
    end
    if (ctl.en_sum) begin
      r <= {{(RES_W-COORD_W-16){c0[COORD_W-1]}}, c0, 16'h0000}
           + {lin_b[RES_W-2:0], 1'b0}
           + quad[RES_W+15:16];
    end
  end

endmodule

// ===== rtl/quadratic_bezier_point_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_point_unit
// One point of a quadratic Bezier curve per step index, as a marker box.
// ----------------------------------------------------------------------------
// Takes one step index per clock while the output side is ready and returns
// one box per index, in order. After an index clamp register, the depth is
// set by the divider that forms t = floor(index*65536/step_count): sixteen
// quotient bits resolved four per stage over four stages, followed by two
// multiply stages, a sum stage and the output register. Each stage holds its
// own valid bit and only stalls when the stage after it is full, so bubbles
// are absorbed. Configuration registers are plain flops written through the
// write port; change them only while no transaction is in flight.
module quadratic_bezier_point_unit import bezp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [WR_DATA_W-1:0] wr_data,
  bezp_in_if.sink              in_ch,
  bezp_out_if.source           out_ch
);

  // configuration
  logic signed [COORD_W-1:0] start_x, start_y, ctrl_x, ctrl_y, end_x, end_y;
  logic [STEP_W-1:0]         step_count;
  logic [RAD_W-1:0]          radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      ctrl_x     <= '0;
      ctrl_y     <= '0;
      end_x      <= '0;
      end_y      <= '0;
      step_count <= STEP_COUNT_RESET;
      radius     <= RADIUS_RESET;
    end else if (wr_en) begin
      unique case (bezp_reg_e'(wr_index))
        REG_START_X:    start_x    <= wr_data[COORD_W-1:0];
        REG_START_Y:    start_y    <= wr_data[COORD_W-1:0];
        REG_CTRL_X:     ctrl_x     <= wr_data[COORD_W-1:0];
        REG_CTRL_Y:     ctrl_y     <= wr_data[COORD_W-1:0];
        REG_END_X:      end_x      <= wr_data[COORD_W-1:0];
        REG_END_Y:      end_y      <= wr_data[COORD_W-1:0];
        REG_STEP_COUNT: step_count <= wr_data[STEP_W-1:0];
        REG_RADIUS:     radius     <= wr_data[RAD_W-1:0];
        default:        ;
      endcase
    end
  end

  // pipeline flow control
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[ST_IDX]) begin
        valid[ST_IDX] <= in_ch.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // nothing is taken while in reset
  assign in_ch.ready = en[ST_IDX] && !rst;

  // index clamp, zero step count behaves as one
  logic [STEP_W-1:0] steps_eff;
  logic [STEP_W-1:0] idx_clamp;
  logic [STEP_W-1:0] idx_c;
  logic              last_pipe [NUM_STAGES];

  assign steps_eff = (step_count == '0) ? STEP_W'(1) : step_count;
  assign idx_clamp = (in_ch.step_index >= steps_eff) ? steps_eff - STEP_W'(1)
                                                     : in_ch.step_index;

  always_ff @(posedge clk) begin
    if (en[ST_IDX]) begin
      idx_c             <= idx_clamp;
      last_pipe[ST_IDX] <= (idx_clamp == steps_eff - STEP_W'(1));
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        last_pipe[k] <= last_pipe[k-1];
      end
    end
  end

  // t = floor(idx*2^16/steps), remainder starts at idx since idx < steps
  logic [STEP_W-1:0] rem_s [DIV_STAGES+1];
  logic [STEP_W-1:0] quo_s [DIV_STAGES+1];

  assign rem_s[0] = idx_c;
  assign quo_s[0] = '0;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    bezp_div_stage u_div (
      .clk     (clk),
      .en      (en[ST_DIV0+j]),
      .divisor (steps_eff),
      .rem_in  (rem_s[j]),
      .quo_in  (quo_s[j]),
      .rem_out (rem_s[j+1]),
      .quo_out (quo_s[j+1])
    );
  end

  // curve point per axis
  bezp_axis_ctl_t    axis_ctl;
  logic [RES_W-1:0]  rx, ry;

  assign axis_ctl.en_mul  = en[ST_MUL];
  assign axis_ctl.en_prod = en[ST_PROD];
  assign axis_ctl.en_sum  = en[ST_SUM];

  bezp_axis u_axis_x (
    .clk (clk),
    .ctl (axis_ctl),
    .t   (quo_s[DIV_STAGES]),
    .c0  (start_x),
    .c1  (ctrl_x),
    .c2  (end_x),
    .r   (rx)
  );

  bezp_axis u_axis_y (
    .clk (clk),
    .ctl (axis_ctl),
    .t   (quo_s[DIV_STAGES]),
    .c0  (start_y),
    .c1  (ctrl_y),
    .c2  (end_y),
    .r   (ry)
  );

  // output register: marker box
  logic [RES_W-1:0] rad_ext;
  logic [RES_W-1:0] x_low_q, y_low_q, x_high_q, y_high_q;

  assign rad_ext = RES_W'(radius);

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      x_low_q  <= rx - rad_ext;
      y_low_q  <= ry - rad_ext;
      x_high_q <= rx + rad_ext;
      y_high_q <= ry + rad_ext;
    end
  end

  assign out_ch.valid     = valid[ST_OUT];
  assign out_ch.x_low     = x_low_q;
  assign out_ch.y_low     = y_low_q;
  assign out_ch.x_high    = x_high_q;
  assign out_ch.y_high    = y_high_q;
  assign out_ch.last_step = last_pipe[ST_OUT];

  // an empty output register means the whole pipeline can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

  // divider remainder must stay below the divisor
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid[ST_MUL-1] |-> (rem_s[DIV_STAGES] < steps_eff))
    else $error("divider remainder out of range");

  // box width is always twice the radius
  a_box_width: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (RES_W'(x_high_q - x_low_q) == RES_W'(rad_ext << 1)) &&
                     (RES_W'(y_high_q - y_low_q) == RES_W'(rad_ext << 1)))
    else $error("marker box width mismatch");

  // a new transaction occupies the first stage on the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> valid[ST_IDX])
    else $error("accepted transaction lost at first stage");

endmodule
